[design/rgb_cube_path_fader_unit_assert.svh]
// Assertion macros for the RGB cube path fader checker.
// Used by rcpf_checker; needs nothing else.
`ifndef RGB_CUBE_PATH_FADER_UNIT_ASSERT_SVH
`define RGB_CUBE_PATH_FADER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define RCPF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high
`define RCPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds through reset
`define RCPF_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[design/rcpf_pkg.sv]
// Shared types, constants and route-table functions for the RGB cube path fader.
// No dependencies; imported by rcpf_cfg_regs, rcpf_walk and the top level.
package rcpf_pkg;

  localparam int LevelW       = 8;
  localparam int CountW       = 16;
  localparam int PosW         = 6;
  localparam int PosDepth     = 64;
  localparam int IndexW       = 2;
  localparam int RouteBytes   = 18;
  localparam int TableCorners = 36;

  // Configuration register indexes
  localparam logic [IndexW-1:0] REG_STEP_DELAY = 2'd0;
  localparam logic [IndexW-1:0] REG_END_WAIT   = 2'd1;

  localparam logic [CountW-1:0] STEP_DELAY_RST = 16'd70;
  localparam logic [CountW-1:0] END_WAIT_RST   = 16'd500;

  // Corner route, two corners per byte, high nibble first
  localparam logic [7:0] ROUTE [RouteBytes] = '{
    8'h01, 8'h23, 8'h76, 8'h54, 8'h03, 8'h21, 8'h56, 8'h74,
    8'h13, 8'h64, 8'h16, 8'h02, 8'h75, 8'h24, 8'h35, 8'h17, 8'h25, 8'h70
  };
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  typedef logic [2:0] corner_t;

  // One move of the walk: origin corner, target corner, position after it
  typedef struct packed {
    corner_t         src;
    corner_t         dst;
    logic [PosW-1:0] pos_next;
  } hop_t;

  typedef struct packed {
    logic [CountW-1:0] step_delay;
    logic [CountW-1:0] end_wait;
  } cfg_regs_t;

  // Corner at a route position; positions past the stored list read corner A
  function automatic corner_t corner_at(int pos);
    logic [7:0] b;
    logic [3:0] nib;
    if (pos >= TableCorners) return '0;
    b = ROUTE[pos >> 1];
    nib = ((pos & 1) != 0) ? (b[3:0] & NIBBLE_MASK) : (b[7:4] & NIBBLE_MASK);
    return nib[2:0];
  endfunction

  // Corner number to color bits: red bit 2, green bit 1, blue bit 0
  function automatic corner_t corner_rgb(corner_t c);
    corner_t rgb;
    case (c)
      3'd0:    rgb = 3'd0;
      3'd1:    rgb = 3'd2;
      3'd2:    rgb = 3'd3;
      3'd3:    rgb = 3'd1;
      3'd4:    rgb = 3'd4;
      3'd5:    rgb = 3'd6;
      3'd6:    rgb = 3'd7;
      default: rgb = 3'd5;
    endcase
    return rgb;
  endfunction

  // Next real move starting at position p: repeated corners are skipped,
  // the route wraps at steps with the previous corner taken as corner A.
  // Evaluated at elaboration only.
  function automatic hop_t find_hop(int steps, int p);
    int      q;
    int      k;
    bit      found;
    corner_t prev;
    corner_t cur;
    hop_t    h;
    q = p;
    found = 1'b0;
    h = '0;
    for (k = 0; k <= PosDepth + 1; k++) begin
      if (!found) begin
        if (q >= steps) q = 0;
        prev = (q == 0) ? corner_t'(0) : corner_at(q - 1);
        cur  = corner_at(q);
        if (cur != prev) begin
          found = 1'b1;
          h.src = prev;
          h.dst = cur;
          h.pos_next = PosW'(q + 1);
        end else begin
          q = q + 1;
        end
      end
    end
    return h;
  endfunction

  // One level step toward a goal
  function automatic logic [LevelW-1:0] toward(logic [LevelW-1:0] cur,
                                               logic [LevelW-1:0] goal);
    if (cur < goal) return cur + 1'b1;
    if (cur > goal) return cur - 1'b1;
    return cur;
  endfunction

endpackage

[design/rcpf_in_if.sv]
// Tick input channel: valid/ready with the restart flag.
// Depends on nothing.
interface rcpf_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

[design/rcpf_out_if.sv]
// Color output channel: valid/ready with the level triple and new_color flag.
// Depends on nothing.
interface rcpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       new_color;

  modport source (output valid, output red, output green, output blue, output new_color,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input new_color,
                  output ready);
endinterface

[design/rcpf_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Depends on nothing.
interface rcpf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/rcpf_cfg_regs.sv]
// Configuration registers step_delay and end_wait.
// Depends on rcpf_pkg and rcpf_cfg_if.
module rcpf_cfg_regs import rcpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rcpf_cfg_if.sink   cfg,
  output cfg_regs_t  regs
);

  // Writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_delay <= STEP_DELAY_RST;
      regs.end_wait   <= END_WAIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_STEP_DELAY: regs.step_delay <= cfg.data;
        REG_END_WAIT:   regs.end_wait   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

[design/rcpf_walk.sv]
// Walk state and per-tick update: route position, hold and rest counters, levels.
// Depends on rcpf_pkg.
module rcpf_walk import rcpf_pkg::*; #(
  parameter int LEVEL_MAX  = 255,
  parameter int LEVEL_MIN  = 0,
  parameter int PATH_STEPS = 36
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              restart,
  input  cfg_regs_t         cfg,
  output logic [LevelW-1:0] red_next,
  output logic [LevelW-1:0] green_next,
  output logic [LevelW-1:0] blue_next,
  output logic              new_color_next
);

  localparam int Span = (LEVEL_MAX > LEVEL_MIN) ? (LEVEL_MAX - LEVEL_MIN) : 0;
  localparam logic [LevelW-1:0] SpanLvl = LevelW'(Span);
  localparam logic [LevelW-1:0] LvlHi   = LevelW'(LEVEL_MAX);
  localparam logic [LevelW-1:0] LvlLo   = LevelW'(LEVEL_MIN);

  typedef enum logic [2:0] {
    PH_FETCH = 3'b001,
    PH_HOLD  = 3'b010,
    PH_REST  = 3'b100
  } phase_t;

  // Move table: for each position, the next move with a real color change
  hop_t hop_tab [PosDepth];
  for (genvar gp = 0; gp < PosDepth; gp++) begin : g_hop
    localparam hop_t Entry = find_hop(PATH_STEPS, gp);
    assign hop_tab[gp] = Entry;
  end

  phase_t            phase, phase_next;
  logic [PosW-1:0]   path_position, path_position_next;
  corner_t           last_corner, last_corner_next;
  logic [LevelW-1:0] steps_done, steps_done_next;
  logic [CountW-1:0] wait_count, wait_count_next;
  logic [LevelW-1:0] level_red, level_green, level_blue;

  phase_t            ph_e;
  logic [PosW-1:0]   pos_e;
  corner_t           last_e;
  logic [LevelW-1:0] steps_e;
  logic [CountW-1:0] wait_e;
  logic [CountW-1:0] hold_ticks;
  logic              do_fetch;
  hop_t              hop;
  corner_t           src_rgb, dst_rgb;

  assign hold_ticks = (cfg.step_delay == '0) ? '0 : cfg.step_delay - 1'b1;

  // Restart pulls the walk back to the start before the tick is handled
  assign ph_e    = restart ? PH_FETCH : phase;
  assign pos_e   = restart ? '0 : path_position;
  assign last_e  = restart ? '0 : last_corner;
  assign steps_e = restart ? '0 : steps_done;
  assign wait_e  = restart ? '0 : wait_count;

  assign hop     = hop_tab[pos_e];
  assign src_rgb = corner_rgb(hop.src);
  assign dst_rgb = corner_rgb(last_e);

  // One tick of the walk
  always_comb begin
    phase_next         = ph_e;
    path_position_next = pos_e;
    last_corner_next   = last_e;
    steps_done_next    = steps_e;
    wait_count_next    = wait_e;
    red_next           = level_red;
    green_next         = level_green;
    blue_next          = level_blue;
    new_color_next     = 1'b0;
    do_fetch           = 1'b0;

    case (ph_e)
      PH_HOLD: begin
        if (wait_e != '0) begin
          wait_count_next = wait_e - 1'b1;
        end else if (steps_e < SpanLvl) begin
          red_next        = toward(level_red,   dst_rgb[2] ? LvlHi : LvlLo);
          green_next      = toward(level_green, dst_rgb[1] ? LvlHi : LvlLo);
          blue_next       = toward(level_blue,  dst_rgb[0] ? LvlHi : LvlLo);
          steps_done_next = steps_e + 1'b1;
          wait_count_next = hold_ticks;
          new_color_next  = 1'b1;
        end else if (cfg.end_wait != '0) begin
          phase_next      = PH_REST;
          wait_count_next = cfg.end_wait - 1'b1;
        end else begin
          do_fetch = 1'b1;
        end
      end
      PH_REST: begin
        if (wait_e != '0) begin
          wait_count_next = wait_e - 1'b1;
        end else begin
          do_fetch = 1'b1;
        end
      end
      default: do_fetch = 1'b1;
    endcase

    // Start the next edge at the origin corner's full levels, or go straight to rest when the span is zero
    if (do_fetch) begin
      path_position_next = hop.pos_next;
      last_corner_next   = hop.dst;
      if (Span == 0) begin
        phase_next      = PH_REST;
        wait_count_next = cfg.end_wait;
      end else begin
        red_next        = src_rgb[2] ? LvlHi : LvlLo;
        green_next      = src_rgb[1] ? LvlHi : LvlLo;
        blue_next       = src_rgb[0] ? LvlHi : LvlLo;
        steps_done_next = LevelW'(1);
        wait_count_next = hold_ticks;
        phase_next      = PH_HOLD;
        new_color_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FETCH;
      path_position <= '0;
      last_corner   <= '0;
      steps_done    <= '0;
      wait_count    <= '0;
      level_red     <= LvlLo;
      level_green   <= LvlLo;
      level_blue    <= LvlLo;
    end else if (fire) begin
      phase         <= phase_next;
      path_position <= path_position_next;
      last_corner   <= last_corner_next;
      steps_done    <= steps_done_next;
      wait_count    <= wait_count_next;
      level_red     <= red_next;
      level_green   <= green_next;
      level_blue    <= blue_next;
    end
  end

endmodule

[design/rgb_cube_path_fader_unit.sv]
// Channel  Dir  Word contents                       Handshake
// tick     in   restart                             valid/ready
// color    out  red, green, blue, new_color         valid/ready
// cfg      in   index, data (step_delay, end_wait)  valid/ready, always ready
//
// One color word per tick word. A tick is registered in the input register, the walk
// update runs from it and its word lands in the output register. One tick is accepted
// every cycle unless a color stall fills both registers. Synchronous reset returns
// the walk to corner A with levels at LEVEL_MIN and clears both valid flags. A stall
// on color holds the output word and the input register; tick ready drops only while
// both are full.
//
// Top level; depends on rcpf_pkg, the channel interfaces, rcpf_cfg_regs, rcpf_walk.
module rgb_cube_path_fader_unit import rcpf_pkg::*; #(
  parameter int LEVEL_MAX  = 255,
  parameter int LEVEL_MIN  = 0,
  parameter int PATH_STEPS = 36
) (
  input  logic        clk,
  input  logic        rst,
  rcpf_in_if.sink     tick,
  rcpf_out_if.source  color,
  rcpf_cfg_if.sink    cfg
);

  cfg_regs_t         regs;
  logic              s1_valid;
  logic              s1_restart;
  logic              out_valid;
  logic              advance;
  logic              fire;
  logic [LevelW-1:0] red_next, green_next, blue_next;
  logic              new_color_next;
  logic [LevelW-1:0] red_q, green_q, blue_q;
  logic              new_color_q;

  rcpf_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Pipeline moves whenever the output register is free or being drained
  assign advance    = !out_valid || color.ready;
  assign tick.ready = !s1_valid || advance;
  assign fire       = s1_valid && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_restart <= tick.restart;
    end
  end

  rcpf_walk #(
    .LEVEL_MAX  (LEVEL_MAX),
    .LEVEL_MIN  (LEVEL_MIN),
    .PATH_STEPS (PATH_STEPS)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .restart        (s1_restart),
    .cfg            (regs),
    .red_next       (red_next),
    .green_next     (green_next),
    .blue_next      (blue_next),
    .new_color_next (new_color_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      red_q       <= red_next;
      green_q     <= green_next;
      blue_q      <= blue_next;
      new_color_q <= new_color_next;
    end
  end

  assign color.valid     = out_valid;
  assign color.red       = red_q;
  assign color.green     = green_q;
  assign color.blue      = blue_q;
  assign color.new_color = new_color_q;

endmodule

[design/rcpf_checker.sv]
// Port-level checks for rgb_cube_path_fader_unit, attached by bind.
// Depends on rgb_cube_path_fader_unit_assert.svh.
`include "rgb_cube_path_fader_unit_assert.svh"

module rcpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       tick_valid,
  input logic       tick_ready,
  input logic       color_valid,
  input logic       color_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       new_color
);

  // Shorthands for the checks below
  logic        stall;
  logic        full_take;
  logic [24:0] cw;

  assign stall     = color_valid && !color_ready;
  assign full_take = tick_valid && tick_ready && stall;
  assign cw        = {red, green, blue, new_color};

  // A stalled color word holds
  `RCPF_ASSERT_NEXT(a_color_hold, clk, rst, stall, color_valid && $stable(cw), "word changed")

  // Reset leaves no color word pending
  `RCPF_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !color_valid, "color valid after reset")

  // With the output register empty the tick side never blocks
  `RCPF_ASSERT_NOW(a_ready_when_empty, clk, rst, !color_valid, tick_ready, "tick blocked")

  // A tick taken under an output stall fills the pipe: ready then follows the drain
  `RCPF_ASSERT_NEXT(a_full_pipe, clk, rst, full_take, tick_ready == color_ready, "ready off")

endmodule

bind rgb_cube_path_fader_unit rcpf_checker u_rcpf_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick.valid),
  .tick_ready  (tick.ready),
  .color_valid (color.valid),
  .color_ready (color.ready),
  .red         (color.red),
  .green       (color.green),
  .blue        (color.blue),
  .new_color   (color.new_color)
);

[dv/rcpf_fade_check.sv]
`timescale 1ns / 1ps
// Checker for the RGB cube path fader: watches the tick, color and cfg channels.
// It predicts each color word from accepted ticks and compares it field by field.
// Depends on rcpf_pkg and the three channel interfaces.
module rcpf_fade_check import rcpf_pkg::*; #(
  parameter int LEVEL_MAX  = 255,
  parameter int LEVEL_MIN  = 0,
  parameter int PATH_STEPS = 36
) (
  input  logic clk,
  input  logic rst,
  rcpf_in_if   tick,
  rcpf_out_if  color,
  rcpf_cfg_if  cfg,
  output int   fail_count,
  output int   owed
);

  typedef enum logic [1:0] {WALK_FETCH, WALK_HOLD, WALK_REST} walk_phase_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       new_color;
  } color_word_t;

  localparam int SPAN = (LEVEL_MAX > LEVEL_MIN) ? (LEVEL_MAX - LEVEL_MIN) : 0;
  localparam int ROUTE_LEN = 36;
  localparam logic [15:0] DELAY_AT_RESET = 16'd70;
  localparam logic [15:0] REST_AT_RESET  = 16'd500;

  // Corner list, one corner per position
  localparam logic [2:0] PATH [ROUTE_LEN] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd6, 3'd5, 3'd4, 3'd0, 3'd3, 3'd2, 3'd1,
    3'd5, 3'd6, 3'd7, 3'd4, 3'd1, 3'd3, 3'd6, 3'd4, 3'd1, 3'd6, 3'd0, 3'd2,
    3'd7, 3'd5, 3'd2, 3'd4, 3'd3, 3'd5, 3'd1, 3'd7, 3'd2, 3'd5, 3'd7, 3'd0
  };
  // Corner number to color bits (red bit 2, green bit 1, blue bit 0)
  localparam logic [2:0] CUBE_RGB [8] = '{
    3'd0, 3'd2, 3'd3, 3'd1, 3'd4, 3'd6, 3'd7, 3'd5
  };

  // Predicted walk state and register copies
  logic [7:0]  lvl_r, lvl_g, lvl_b;
  logic [5:0]  route_pos;
  logic [2:0]  prev_corner;
  logic [7:0]  steps_taken;
  logic [15:0] count_left;
  walk_phase_t walk_phase;
  logic [15:0] delay_reg, rest_reg;

  color_word_t owed_colors[$];
  int          words_checked;

  function automatic logic [2:0] path_corner(int p);
    if (p >= ROUTE_LEN) return 3'd0;
    return PATH[p];
  endfunction

  function automatic logic [7:0] rail(bit on);
    return on ? 8'(LEVEL_MAX) : 8'(LEVEL_MIN);
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] lvl, logic [7:0] goal);
    if (lvl < goal) return lvl + 8'd1;
    if (lvl > goal) return lvl - 8'd1;
    return lvl;
  endfunction

  // A zero delay behaves like one tick per color
  function automatic logic [15:0] hold_len();
    return (delay_reg == 16'd0) ? 16'd0 : delay_reg - 16'd1;
  endfunction

  task automatic reset_walk();
    lvl_r = 8'(LEVEL_MIN);
    lvl_g = 8'(LEVEL_MIN);
    lvl_b = 8'(LEVEL_MIN);
    route_pos = '0;
    prev_corner = '0;
    steps_taken = '0;
    count_left = '0;
    walk_phase = WALK_FETCH;
  endtask

  // One tick of the walk; returns the word shown after it
  task automatic advance_walk(input logic restart, output color_word_t w);
    bit         settled;
    bit         lit;
    int         n;
    logic [2:0] from_c;
    logic [2:0] to_c;
    logic [2:0] rgb_from;
    logic [2:0] rgb_to;
    if (restart) begin
      route_pos = '0;
      prev_corner = '0;
      steps_taken = '0;
      count_left = '0;
      walk_phase = WALK_FETCH;
    end
    settled = 1'b0;
    lit = 1'b0;
    for (n = 0; n < 200 && !settled; n++) begin
      case (walk_phase)
        WALK_FETCH: begin
          if (int'(route_pos) >= PATH_STEPS) begin
            route_pos = '0;
            prev_corner = '0;
          end
          to_c = path_corner(int'(route_pos));
          route_pos = route_pos + 6'd1;
          from_c = prev_corner;
          prev_corner = to_c;
          rgb_from = CUBE_RGB[from_c];
          rgb_to = CUBE_RGB[to_c];
          // equal colors: the move costs no tick
          if (rgb_from != rgb_to) begin
            if (SPAN == 0) begin
              walk_phase = WALK_REST;
              count_left = rest_reg;
            end else begin
              lvl_r = rail(rgb_from[2]);
              lvl_g = rail(rgb_from[1]);
              lvl_b = rail(rgb_from[0]);
              steps_taken = 8'd1;
              count_left = hold_len();
              walk_phase = WALK_HOLD;
              lit = 1'b1;
              settled = 1'b1;
            end
          end
        end
        WALK_HOLD: begin
          if (count_left > 0) begin
            count_left = count_left - 16'd1;
            settled = 1'b1;
          end else if (int'(steps_taken) < SPAN) begin
            rgb_to = CUBE_RGB[prev_corner];
            lvl_r = nudge(lvl_r, rail(rgb_to[2]));
            lvl_g = nudge(lvl_g, rail(rgb_to[1]));
            lvl_b = nudge(lvl_b, rail(rgb_to[0]));
            steps_taken = steps_taken + 8'd1;
            count_left = hold_len();
            lit = 1'b1;
            settled = 1'b1;
          end else begin
            walk_phase = WALK_REST;
            count_left = rest_reg;
          end
        end
        WALK_REST: begin
          if (count_left > 0) begin
            count_left = count_left - 16'd1;
            settled = 1'b1;
          end else begin
            walk_phase = WALK_FETCH;
          end
        end
        default: walk_phase = WALK_FETCH;
      endcase
    end
    w.red = lvl_r;
    w.green = lvl_g;
    w.blue = lvl_b;
    w.new_color = lit;
  endtask

  task automatic note_mismatch(input string msg);
    $display("%0t ns  %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    owed = 0;
    words_checked = 0;
    delay_reg = DELAY_AT_RESET;
    rest_reg = REST_AT_RESET;
    reset_walk();
  end

  // Sample all three channels on the rising edge
  always @(posedge clk) begin : watch
    color_word_t want;
    color_word_t seen;
    if (rst) begin
      reset_walk();
      delay_reg = DELAY_AT_RESET;
      rest_reg = REST_AT_RESET;
      owed_colors.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_STEP_DELAY: delay_reg = cfg.data;
          REG_END_WAIT:   rest_reg = cfg.data;
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        advance_walk(tick.restart, want);
        owed_colors.push_back(want);
      end
      if (color.valid && color.ready) begin
        seen.red = color.red;
        seen.green = color.green;
        seen.blue = color.blue;
        seen.new_color = color.new_color;
        if (owed_colors.size() == 0) begin
          note_mismatch($sformatf("color word %0d arrived with no tick owed: %h",
                                  words_checked, seen));
        end else begin
          want = owed_colors.pop_front();
          if (seen.red !== want.red)
            note_mismatch($sformatf("color word %0d: red %0d, predicted %0d",
                                    words_checked, seen.red, want.red));
          if (seen.green !== want.green)
            note_mismatch($sformatf("color word %0d: green %0d, predicted %0d",
                                    words_checked, seen.green, want.green));
          if (seen.blue !== want.blue)
            note_mismatch($sformatf("color word %0d: blue %0d, predicted %0d",
                                    words_checked, seen.blue, want.blue));
          if (seen.new_color !== want.new_color)
            note_mismatch($sformatf("color word %0d: new_color %0b, predicted %0b",
                                    words_checked, seen.new_color, want.new_color));
        end
        words_checked++;
      end
    end
    owed = owed_colors.size();
  end

endmodule

[dv/rgb_cube_path_fader_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the RGB cube path fader testbench: clock, reset, tick and cfg stimulus,
// color receiver and verdict. Depends on rcpf_pkg, the interfaces and rcpf_fade_check.
module rgb_cube_path_fader_unit_tb;
  import rcpf_pkg::*;

  localparam int LEVEL_MAX   = 255;
  localparam int LEVEL_MIN   = 0;
  localparam int PATH_STEPS  = 36;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_LEN   = 12;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;

  // Indexes with no register behind them
  localparam logic [IndexW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IndexW-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst;

  int fail_count;
  int owed;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_asks;
  int quiet_cycles;

  rcpf_in_if  tick_ch ();
  rcpf_out_if color_ch ();
  rcpf_cfg_if cfg_ch ();

  always #HALF_PERIOD clk = ~clk;

  rgb_cube_path_fader_unit #(
    .LEVEL_MAX (LEVEL_MAX),
    .LEVEL_MIN (LEVEL_MIN),
    .PATH_STEPS(PATH_STEPS)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .tick (tick_ch),
    .color(color_ch),
    .cfg  (cfg_ch)
  );

  rcpf_fade_check #(
    .LEVEL_MAX (LEVEL_MAX),
    .LEVEL_MIN (LEVEL_MIN),
    .PATH_STEPS(PATH_STEPS)
  ) u_fade_check (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .color     (color_ch),
    .cfg       (cfg_ch),
    .fail_count(fail_count),
    .owed      (owed)
  );

  // Color receiver: random idling, plus a long hold-off when asked
  initial begin : color_sink
    int stall_left;
    int asks_seen;
    stall_left = 0;
    asks_seen = 0;
    color_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_asks != asks_seen) begin
        asks_seen = hold_off_asks;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        color_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        color_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after too long with no word moving
  always @(posedge clk) begin : watchdog
    if (rst || (tick_ch.valid && tick_ch.ready) || (color_ch.valid && color_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one tick word; called and returns at a falling edge, valid left high
  task automatic send_tick(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.restart <= restart;
    @(posedge clk);
    while (!(tick_ch.valid && tick_ch.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Registers change only with the block idle
  task automatic program_regs(input logic [15:0] delay, input logic [15:0] rest);
    tick_ch.valid <= 1'b0;
    wait_drained();
    write_reg(REG_STEP_DELAY, delay);
    write_reg(REG_END_WAIT, rest);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] delay, input logic [15:0] rest,
                           input int n_ticks, input int send_pct, input int recv_pct,
                           input bit hold_off, input bit mid_drain);
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    program_regs(delay, rest);
    for (i = 0; i < n_ticks; i++) begin
      if (i == n_ticks / 2) begin
        if (hold_off) hold_off_asks++;
        if (mid_drain) begin
          tick_ch.valid <= 1'b0;
          wait_drained();
        end
      end
      send_tick($urandom_range(299) == 0);
    end
    tick_ch.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : stimulus
    int i;
    rst = 1'b1;
    tick_ch.valid = 1'b0;
    tick_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_STEP_DELAY;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_asks = 0;
    quiet_cycles = 0;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings, first color of the first edge, a restart
    for (i = 0; i < 3; i++) send_tick(1'b0);
    send_tick(1'b1);

    // Writes to spare indexes, then zero hold: a new color every tick, restarts mid-edge and back to back
    tick_ch.valid <= 1'b0;
    wait_drained();
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'hffff);
    cfg_ch.valid <= 1'b0;
    program_regs(16'd0, 16'd0);
    for (i = 0; i < 8; i++) send_tick(1'b0);
    send_tick(1'b1);
    for (i = 0; i < 3; i++) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);

    // Largest hold and rest
    program_regs(16'hffff, 16'hffff);
    for (i = 0; i < 3; i++) send_tick(1'b0);
    send_tick(1'b1);

    // Random part: sender idles lightly, receiver heavily
    run_phase(16'd0, 16'd0, 300, 17, 58, 1'b1, 1'b0);
    run_phase(16'd1, 16'd2, 170, 17, 58, 1'b0, 1'b0);
    // Receiver idles lightly, sender heavily; one full drain mid-phase
    run_phase(16'd2, 16'd1, 300, 58, 17, 1'b0, 1'b1);
    run_phase(16'($urandom_range(3)), 16'($urandom_range(40)), 170, 58, 17, 1'b0, 1'b0);
    // No idling; long receiver hold-off fills the block
    run_phase(16'd0, 16'hffff, 200, 0, 0, 1'b0, 1'b0);
    run_phase(16'd1, 16'd0, 200, 0, 0, 1'b1, 1'b0);
    run_phase(16'hffff, 16'd0, 60, 0, 0, 1'b0, 1'b0);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[rgb_cube_path_fader_unit.f]
+incdir+design
design/rcpf_pkg.sv
design/rcpf_in_if.sv
design/rcpf_out_if.sv
design/rcpf_cfg_if.sv
design/rcpf_cfg_regs.sv
design/rcpf_walk.sv
design/rgb_cube_path_fader_unit.sv
design/rcpf_checker.sv
dv/rcpf_fade_check.sv
dv/rgb_cube_path_fader_unit_tb.sv
